// ===== design/brb_pkg.sv =====
// Shared types and codes of the byte ring buffer FIFO.
package brb_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_PEEK  = 2'd2;
	localparam logic [1:0] FUNC_FLUSH = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	// Fixed field widths.
	localparam int LEN_W   = 7;
	localparam int CNT_W   = 11;
	localparam int TOT_W   = 64;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	typedef struct packed {
		logic [7:0]       data_out;
		logic [1:0]       status;
		logic [CNT_W-1:0] moved_count;
		logic [CNT_W-1:0] fill_now;
		logic [CNT_W-1:0] free_now;
		logic [TOT_W-1:0] total_in;
		logic [TOT_W-1:0] total_out;
		logic             last_of_run;
	} res_t;

endpackage

// ===== design/byte_ring_buffer_fifo_top.sv =====
// Top level of the byte ring buffer FIFO: ring control, byte store and output register.
// A write, flush, zero-length or underflow word gives its result in the cycle after it is
// accepted; a read or peek burst passes its first byte through the sequencer state, which
// issues the read, the synchronous byte store and the output register, and then gives one
// byte per cycle while the consumer takes them.
// Throughput: one write word per cycle while the consumer takes results; a burst keeps the
// input closed until its last byte has gone to the output register. Reset (arst_n low) clears
// pointers, fill, totals and request tracking at once; the byte store has no reset and needs
// no clearing pass, since only written entries are ever read.
module byte_ring_buffer_fifo_top #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // data_byte[7:0], request_len[14:8], zero pad[15]
	input  logic [1:0]   s_tuser,  // func[1:0]
	input  logic         s_tlast,  // end_of_write
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,  // data_out[7:0], status[9:8], moved_count[20:10],
	                               // fill_now[31:21], free_now[42:32], total_in[106:43],
	                               // total_out[170:107], zero pad[175:171]
	output logic         m_tlast   // last_of_run
);

	import brb_pkg::*;

	// Pointer width addresses the byte store; fill width can hold DEPTH itself.
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic          res_ready, res_valid;
	res_t          res, out_q;
	logic          m_tvalid_q;
	logic          mem_we, mem_re;
	logic [PW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	// The output register takes a new result when empty or when its word leaves this cycle,
	// so the control side never waits longer than the consumer.
	assign res_ready = !m_tvalid_q || m_tready;

	brb_ctrl #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST),
		.PW        (PW),
		.FW        (FW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.func         (s_tuser),
		.data_byte    (s_tdata[7:0]),
		.request_len  (s_tdata[14:8]),
		.end_of_write (s_tlast),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	brb_ram #(
		.DEPTH (DEPTH),
		.AW    (PW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_q.last_of_run;
	assign m_tdata  = {5'b0, out_q.total_out, out_q.total_in, out_q.free_now,
	                   out_q.fill_now, out_q.moved_count, out_q.status, out_q.data_out};

endmodule

// ===== design/brb_ram.sv =====
// Byte store of the ring: one write port, one registered read port.
module brb_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/brb_ctrl.sv =====
// Ring control: pointers, fill, totals, request tracking and the read burst sequencer.
module brb_ctrl #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64,
	parameter int PW        = 10,
	parameter int FW        = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [7:0]               data_byte,
	input  logic [brb_pkg::LEN_W-1:0] request_len,
	input  logic                     end_of_write,
	input  logic                     res_ready,
	output logic                     res_valid,
	output brb_pkg::res_t            res,
	output logic                     mem_we,
	output logic [PW-1:0]            mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic                     mem_re,
	output logic [PW-1:0]            mem_raddr,
	input  logic [7:0]               mem_rdata
);

	import brb_pkg::*;

	localparam int SW = ((FW > LEN_W) ? FW : LEN_W) + 1;

	state_t           st_q, st_d;
	logic [PW-1:0]    rp_q, rp_d, wp_q, wp_d, bp_q, bp_d;
	logic [FW-1:0]    fill_q, fill_d;
	logic [TOT_W-1:0] tin_q, tin_d, tout_q, tout_d;
	logic [CNT_W-1:0] rw_q, rw_d, rw_new;
	logic             rd_q, rd_d, rd_new;
	logic [LEN_W-1:0] remain_q, remain_d, n_q, n_d;
	logic             pend_q, pend_d;

	logic             accept, push, issue;
	logic [LEN_W-1:0] req_sat, n_w;
	logic [SW-1:0]    rp_sum;

	function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p);
		next_idx = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_ready = (st_q == ST_IDLE) && res_ready;
	assign accept   = in_valid && in_ready;
	assign req_sat  = (request_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : request_len;
	assign n_w      = (SW'(req_sat) < SW'(fill_q)) ? req_sat : LEN_W'(fill_q);
	assign rp_sum   = (SW'(rp_q) + SW'(n_w) >= SW'(DEPTH)) ?
	                  SW'(rp_q) + SW'(n_w) - SW'(DEPTH) : SW'(rp_q) + SW'(n_w);

	assign mem_waddr = wp_q;
	assign mem_wdata = data_byte;
	assign mem_raddr = bp_q;
	assign push      = (st_q == ST_BURST) && pend_q && res_ready;
	assign issue     = (st_q == ST_BURST) && (remain_q != '0) && (!pend_q || push);
	assign mem_re    = issue;

	always_comb begin
		st_d     = st_q;
		rp_d     = rp_q;
		wp_d     = wp_q;
		bp_d     = bp_q;
		fill_d   = fill_q;
		tin_d    = tin_q;
		tout_d   = tout_q;
		rw_d     = rw_q;
		rd_d     = rd_q;
		remain_d = remain_q;
		n_d      = n_q;
		pend_d   = pend_q;
		rw_new   = rw_q;
		rd_new   = rd_q;
		mem_we   = 1'b0;
		res_valid       = 1'b0;
		res.data_out    = '0;
		res.status      = STAT_OK;
		res.moved_count = '0;
		res.last_of_run = 1'b1;

		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_WRITE: begin
							if (fill_q != FW'(DEPTH)) begin
								mem_we = 1'b1;
								wp_d   = next_idx(wp_q);
								fill_d = fill_q + 1'b1;
								tin_d  = tin_q + 1'b1;
								rw_new = (rw_q == CNT_MAX) ? rw_q : rw_q + 1'b1;
							end else begin
								rd_new = 1'b1;
							end
							res_valid       = 1'b1;
							res.status      = rd_new ? STAT_OVERFLOW : STAT_OK;
							res.moved_count = rw_new;
							rw_d = end_of_write ? '0 : rw_new;
							rd_d = end_of_write ? 1'b0 : rd_new;
						end
						FUNC_FLUSH: begin
							rp_d      = '0;
							wp_d      = '0;
							fill_d    = '0;
							res_valid = 1'b1;
						end
						default: begin
							if (func == FUNC_READ && req_sat == '0) begin
								res_valid = 1'b1;
							end else if (fill_q == '0) begin
								res_valid  = 1'b1;
								res.status = STAT_UNDERFLOW;
							end else if (n_w == '0) begin
								res_valid = 1'b1;
							end else begin
								st_d     = ST_BURST;
								bp_d     = rp_q;
								remain_d = n_w;
								n_d      = n_w;
								if (func == FUNC_READ) begin
									rp_d   = PW'(rp_sum);
									fill_d = fill_q - FW'(n_w);
									tout_d = tout_q + TOT_W'(n_w);
								end
							end
						end
					endcase
				end
			end
			ST_BURST: begin
				if (issue) begin
					bp_d     = next_idx(bp_q);
					remain_d = remain_q - 1'b1;
				end
				pend_d = issue ? 1'b1 : (push ? 1'b0 : pend_q);
				if (push) begin
					res_valid       = 1'b1;
					res.data_out    = mem_rdata;
					res.moved_count = CNT_W'(n_q);
					res.last_of_run = (remain_q == '0);
					if (remain_q == '0) begin
						st_d = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase

		// Every result carries the state as it stands after its item.
		res.fill_now  = CNT_W'(fill_d);
		res.free_now  = CNT_W'(FW'(DEPTH) - fill_d);
		res.total_in  = tin_d;
		res.total_out = tout_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rp_q     <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
			tin_q    <= '0;
			tout_q   <= '0;
			rw_q     <= '0;
			rd_q     <= 1'b0;
			remain_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			st_q     <= st_d;
			rp_q     <= rp_d;
			wp_q     <= wp_d;
			fill_q   <= fill_d;
			tin_q    <= tin_d;
			tout_q   <= tout_d;
			rw_q     <= rw_d;
			rd_q     <= rd_d;
			remain_q <= remain_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		bp_q <= bp_d;
		n_q  <= n_d;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count exceeds ring depth");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (!pend_q && remain_q == '0))
		else $error("burst bookkeeping left over in idle");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result pushed into a full output register");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(push && remain_q == '0) |=> (st_q == ST_IDLE))
		else $error("sequencer did not return to idle after last byte");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench of the byte ring buffer FIFO: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import brb_pkg::*;

	// The bench runs the block at its default geometry.
	localparam int RING_DEPTH = 1024;
	localparam int BURST_MAX  = 64;

	// A generous bound on the run. The slowest correct run sends roughly 3,400 words and
	// collects under 16,000 result words; even if every one of them waited out the longest
	// receiver stall and sender gap, the run would stay well under this limit.
	localparam int CYCLE_LIMIT = 4_000_000;

	// Cycles allowed after the last expected word, to catch any stray result.
	localparam int DRAIN_CYCLES = 20;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata  = '0;   // data_byte[7:0], request_len[14:8], zero pad[15]
	logic [1:0]   s_tuser  = FUNC_WRITE; // func[1:0]
	logic         s_tlast  = 1'b0; // end_of_write
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;         // data_out[7:0], status[9:8], moved_count[20:10],
	                               // fill_now[31:21], free_now[42:32], total_in[106:43],
	                               // total_out[170:107], zero pad[175:171]
	logic         m_tlast;         // last_of_run

	byte_ring_buffer_fifo_top #(
		.DEPTH     (RING_DEPTH),
		.MAX_BURST (BURST_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Predicted contents and counters of the ring. The byte store is only ever read over
	// entries that the predictor itself has written, exactly as in the block.
	logic [7:0]        ring_mem [RING_DEPTH];
	int unsigned       rd_ptr;
	int unsigned       wr_ptr;
	int unsigned       ring_fill;
	logic [TOT_W-1:0]  bytes_in;
	logic [TOT_W-1:0]  bytes_out;
	logic [CNT_W-1:0]  req_written;
	logic              req_dropped;

	// Result words still owed by the block, oldest first.
	res_t expected_words [$];

	int  errors       = 0;
	int  cycle_count  = 0;
	bit  sender_gaps  = 1'b1;

	// Gap lengths: half of them none, most of the rest short and a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(12, 30);
	endfunction

	// Burst lengths for reads and peeks: zero and the maximum often, short bursts mostly,
	// and now and then a request above the maximum, which the block must saturate.
	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return LEN_W'(BURST_MAX);
		else if (r < 7)
			return LEN_W'($urandom_range(1, 16));
		else if (r < 9)
			return LEN_W'($urandom_range(17, BURST_MAX));
		else
			return LEN_W'($urandom_range(BURST_MAX + 1, 127));
	endfunction

	// Queues one expected result word. Every word of an item carries the ring state as it
	// stands after the whole item, so this is called once the state has been updated.
	task automatic owe_word(input logic [7:0] data, input logic [1:0] stat,
	                        input logic [CNT_W-1:0] moved, input logic last);
		res_t w;
		w.data_out    = data;
		w.status      = stat;
		w.moved_count = moved;
		w.fill_now    = CNT_W'(ring_fill);
		w.free_now    = CNT_W'(RING_DEPTH - ring_fill);
		w.total_in    = bytes_in;
		w.total_out   = bytes_out;
		w.last_of_run = last;
		expected_words.push_back(w);
	endtask

	// Works out the result words of one accepted word and advances the predicted ring.
	task automatic ring_predict(input logic [1:0] func, input logic [7:0] data_byte,
	                            input logic [LEN_W-1:0] request_len, input logic end_of_write);
		int unsigned want;
		int unsigned n;
		int unsigned p;
		logic [7:0]  burst [$];
		want = (request_len > BURST_MAX) ? BURST_MAX : request_len;
		case (func)
			FUNC_WRITE: begin
				// A full ring drops the byte and marks the whole request as overflowed.
				if (ring_fill < RING_DEPTH) begin
					ring_mem[wr_ptr] = data_byte;
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					ring_fill++;
					bytes_in++;
					if (req_written < CNT_MAX)
						req_written++;
				end else begin
					req_dropped = 1'b1;
				end
				owe_word(8'h00, req_dropped ? STAT_OVERFLOW : STAT_OK, req_written, 1'b1);
				// The request tracking clears only after the final byte has reported.
				if (end_of_write) begin
					req_written = '0;
					req_dropped = 1'b0;
				end
			end
			FUNC_FLUSH: begin
				// Pointers and fill go, but totals and the request in progress stay.
				rd_ptr    = 0;
				wr_ptr    = 0;
				ring_fill = 0;
				owe_word(8'h00, STAT_OK, '0, 1'b1);
			end
			default: begin
				if (func == FUNC_READ && want == 0) begin
					// A zero-length read succeeds even on an empty ring.
					owe_word(8'h00, STAT_OK, '0, 1'b1);
				end else if (ring_fill == 0) begin
					owe_word(8'h00, STAT_UNDERFLOW, '0, 1'b1);
				end else if (want == 0) begin
					owe_word(8'h00, STAT_OK, '0, 1'b1);
				end else begin
					n = (want < ring_fill) ? want : ring_fill;
					p = rd_ptr;
					repeat (n) begin
						burst.push_back(ring_mem[p]);
						p = (p + 1) % RING_DEPTH;
					end
					// Only a read consumes the bytes; a peek leaves the ring untouched.
					if (func == FUNC_READ) begin
						rd_ptr     = p;
						ring_fill -= n;
						bytes_out += n;
					end
					for (int i = 0; i < n; i++)
						owe_word(burst[i], STAT_OK, CNT_W'(n), i == n - 1);
				end
			end
		endcase
	endtask

	// Offers one word on the input side after an optional random gap and returns once it
	// has been accepted. The call always begins just after a rising edge, so valid is
	// changed at most once in any time step.
	task automatic send_word(input logic [1:0] func, input logic [7:0] data_byte,
	                         input logic [LEN_W-1:0] request_len, input logic end_of_write);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {1'b0, request_len, data_byte};
		s_tlast  <= end_of_write;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ring_predict(func, data_byte, request_len, end_of_write);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Each result word accepted at a rising edge is matched against the oldest expectation.
	always @(posedge clk) begin : result_checker
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("data_out",    want.data_out,    m_tdata[7:0]);
				check_field("status",      want.status,      m_tdata[9:8]);
				check_field("moved_count", want.moved_count, m_tdata[20:10]);
				check_field("fill_now",    want.fill_now,    m_tdata[31:21]);
				check_field("free_now",    want.free_now,    m_tdata[42:32]);
				check_field("total_in",    want.total_in,    m_tdata[106:43]);
				check_field("total_out",   want.total_out,   m_tdata[170:107]);
				check_field("last_of_run", want.last_of_run, m_tlast);
			end
		end
	end

	// The receiver takes words in runs of random length and then stalls for a random gap.
	// Now and then it stays ready for a long stretch so that bursts also flow unbroken.
	initial begin : result_receiver
		int hold;
		@(negedge clk);
		forever begin
			hold = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300) : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (hold) @(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// An empty ring after reset: a zero-length read succeeds, every other read or peek
	// underflows, and a flush of nothing still reports success.
	task automatic test_empty_ring();
		send_word(FUNC_READ,  8'h00, 7'd0,   1'b0);
		send_word(FUNC_READ,  8'hFF, 7'd5,   1'b1);
		send_word(FUNC_PEEK,  8'h00, 7'd0,   1'b0);
		send_word(FUNC_PEEK,  8'h00, 7'd64,  1'b0);
		send_word(FUNC_READ,  8'h00, 7'd127, 1'b0);
		send_word(FUNC_FLUSH, 8'hFF, 7'd127, 1'b1);
	endtask

	// Extreme byte values, a zero-length peek on a filled ring, saturated requests, a burst
	// cut short by the fill, and a flush in the middle of a write request.
	task automatic test_basic_traffic();
		send_word(FUNC_WRITE, 8'h00, 7'd0,   1'b0);
		send_word(FUNC_WRITE, 8'hFF, 7'd127, 1'b0);
		send_word(FUNC_WRITE, 8'hA5, 7'd0,   1'b0);
		send_word(FUNC_WRITE, 8'h5A, 7'd0,   1'b1);
		send_word(FUNC_PEEK,  8'h00, 7'd0,   1'b0);
		send_word(FUNC_PEEK,  8'h00, 7'd127, 1'b0);
		send_word(FUNC_READ,  8'h00, 7'd2,   1'b0);
		send_word(FUNC_READ,  8'h00, 7'd64,  1'b0);
		send_word(FUNC_WRITE, 8'h81, 7'd0,   1'b0);
		send_word(FUNC_WRITE, 8'h7E, 7'd0,   1'b0);
		send_word(FUNC_WRITE, 8'h3C, 7'd0,   1'b0);
		// The flush empties the ring but the request count carries on from three.
		send_word(FUNC_FLUSH, 8'h00, 7'd0,   1'b0);
		send_word(FUNC_WRITE, 8'hC3, 7'd0,   1'b1);
		send_word(FUNC_READ,  8'h00, 7'd1,   1'b0);
	endtask

	// Fills the ring to the brim, overflows it within one request and in a fresh one, then
	// drains it in bursts so that both pointers wrap.
	task automatic test_full_ring();
		sender_gaps = 1'b0;
		send_word(FUNC_FLUSH, 8'h00, 7'd0, 1'b0);
		for (int k = 0; k < RING_DEPTH; k++)
			send_word(FUNC_WRITE, 8'($urandom), 7'($urandom), 1'b0);
		send_word(FUNC_WRITE, 8'h11, 7'd0, 1'b0);
		send_word(FUNC_WRITE, 8'h22, 7'd0, 1'b0);
		send_word(FUNC_WRITE, 8'h33, 7'd0, 1'b1);
		send_word(FUNC_WRITE, 8'h44, 7'd0, 1'b1);
		send_word(FUNC_PEEK,  8'h00, 7'd127, 1'b0);
		send_word(FUNC_READ,  8'h00, 7'd127, 1'b0);
		send_word(FUNC_WRITE, 8'h55, 7'd0, 1'b1);
		while (ring_fill > 0)
			send_word(FUNC_READ, 8'($urandom), 7'($urandom_range(33, 127)), 1'($urandom));
		send_word(FUNC_READ, 8'h00, 7'd1, 1'b0);
		sender_gaps = 1'b1;
	endtask

	// One write request long enough to saturate its byte count. Reads make room whenever
	// the ring fills, so that no byte is dropped and the count keeps climbing.
	task automatic test_long_request();
		localparam int LONG_LEN = 2060;
		sender_gaps = 1'b0;
		send_word(FUNC_FLUSH, 8'h00, 7'd0, 1'b0);
		for (int k = 0; k < LONG_LEN; k++) begin
			if (ring_fill == RING_DEPTH)
				send_word(FUNC_READ, 8'h00, LEN_W'(BURST_MAX), 1'b0);
			send_word(FUNC_WRITE, 8'($urandom), 7'($urandom), k == LONG_LEN - 1);
		end
		send_word(FUNC_FLUSH, 8'h00, 7'd0, 1'b0);
		sender_gaps = 1'b1;
	endtask

	// Random traffic: mostly write requests closed by an end marker, interleaved with reads,
	// peeks and the odd flush. A few requests lose their end marker to act as noise.
	task automatic test_random_traffic();
		localparam int RANDOM_ITEMS = 170;
		int sent;
		int r;
		int n;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				n = $urandom_range(1, 24);
				for (int k = 0; k < n; k++)
					send_word(FUNC_WRITE, 8'($urandom), 7'($urandom),
					          (k == n - 1) ? ($urandom_range(0, 9) != 0) : 1'b0);
				sent += n;
			end else begin
				if (r < 75)
					send_word(FUNC_READ, 8'($urandom), pick_len(), 1'($urandom));
				else if (r < 93)
					send_word(FUNC_PEEK, 8'($urandom), pick_len(), 1'($urandom));
				else
					send_word(FUNC_FLUSH, 8'($urandom), 7'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin : run_tests
		rd_ptr      = 0;
		wr_ptr      = 0;
		ring_fill   = 0;
		bytes_in    = '0;
		bytes_out   = '0;
		req_written = '0;
		req_dropped = 1'b0;

		// Reset is held low from the start and released once, away from the rising edge.
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_basic_traffic();
		test_full_ring();
		test_long_request();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Every owed word must come out; the watchdog catches a block that stops short.
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
design/brb_pkg.sv
design/brb_ram.sv
design/brb_ctrl.sv
design/byte_ring_buffer_fifo_top.sv
bench/tb_top.sv
